[rtl/mmns_pkg.sv]
// ----------------------------------------------------------------------------
// mmns_pkg
// Types and codes shared by the min/max N selector and its cells.
// ----------------------------------------------------------------------------
package mmns_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic {
        REG_KEEP_COUNT     = 1'b0,
        REG_SELECT_LARGEST = 1'b1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;        // write the new value into the chain this cycle
        logic replace_first; // drop the lowest entry and shift toward cell 0
    } cell_ctrl_t;

endpackage

[rtl/mmns_cell.sv]
// ----------------------------------------------------------------------------
// mmns_cell
// One slot of the sorted chain: holds a value, compares it with the offered
// sample and takes its own, its neighbor's or the sample value on an insert.
// ----------------------------------------------------------------------------
module mmns_cell (
    input  logic                                aclk,
    input  mmns_pkg::cell_ctrl_t                ctrl,
    input  logic signed [mmns_pkg::VALUE_W-1:0] sample,
    input  logic                                slot_valid,
    input  logic signed [mmns_pkg::VALUE_W-1:0] left_value,
    input  logic                                left_le,
    input  logic signed [mmns_pkg::VALUE_W-1:0] right_value,
    input  logic                                right_le,
    output logic signed [mmns_pkg::VALUE_W-1:0] value,
    output logic                                le,
    output logic                                ge
);
    import mmns_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // The chain is ascending, so the valid cells with le set form a prefix.
    assign le    = slot_valid && (value_reg <= sample);
    assign ge    = value_reg >= sample;
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert) begin
            if (ctrl.replace_first) begin
                if (right_le) begin
                    value_next = right_value;
                end else if (le) begin
                    value_next = sample;
                end
            end else begin
                if (!le) begin
                    value_next = left_le ? sample : left_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

[rtl/min_max_n_selector.sv]
// ----------------------------------------------------------------------------
// min_max_n_selector
// Keeps the N smallest or largest signed values in a sorted chain of cells
// and streams them out on a read.
//
// Channel  Dir  Contents (low bit first)                  Transaction
// s_       in   tdata: sample_value; tuser: operation,    one command
//                is_null
// m_       out  tdata: kept_value; tuser: has_value;      one kept value
//                tlast: last_item
// cfg_     in   index 0 keep_count, 1 select_largest       one register write
//
// Inserts and clears are taken while idle; inserts may arrive back to back.
// A read holds s_tready low while the output register walks the chain, one
// value per cycle: fill count values (one for an empty store).
// Output stalls pause the walk; the chain itself is not touched while reading.
// Reset is synchronous: keep count 1, smallest mode, empty store, idle control.
// ----------------------------------------------------------------------------
module min_max_n_selector #(
    parameter int CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] sample_value
    input  logic [2:0]                    s_tuser,   // [1:0] operation, [2] is_null

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] kept_value
    output logic                          m_tuser,   // [0] has_value
    output logic                          m_tlast,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mmns_pkg::KEEP_W-1:0]   cfg_wdata
);
    import mmns_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = (FW > KEEP_W) ? FW : KEEP_W;

    logic [KEEP_W-1:0] keep_count_reg;
    logic              select_largest_reg;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic [FW-1:0]     rd_cnt_reg;
    logic [FW-1:0]     rd_cnt_next;
    state_t            state_reg;
    state_t            state_next;

    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    logic signed [VALUE_W-1:0] sample;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_le;
    logic [CAPACITY-1:0]       cell_ge;
    logic [CAPACITY-1:0]       slot_valid;
    cell_ctrl_t                ctrl;

    logic          accept;
    logic          op_insert;
    logic          op_read;
    logic          op_clear;
    logic [CW-1:0] eff_count;
    logic          full;
    logic          better;
    logic          load_out;
    logic          last_now;
    logic [FW-1:0] rd_pos;
    logic [IW-1:0] rd_idx;

    assign sample    = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign op_insert = accept && (s_tuser[1:0] == OP_INSERT) && !s_tuser[2];
    assign op_read   = accept && (s_tuser[1:0] == OP_READ);
    assign op_clear  = accept && (s_tuser[1:0] == OP_CLEAR);

    // Keep count is clamped into 1..CAPACITY.
    always_comb begin
        if (keep_count_reg == '0) begin
            eff_count = CW'(1);
        end else if (CW'(keep_count_reg) > CW'(CAPACITY)) begin
            eff_count = CW'(CAPACITY);
        end else begin
            eff_count = CW'(keep_count_reg);
        end
    end

    assign full = CW'(fill_reg) >= eff_count;

    // A full store takes the sample only if it beats the worst kept value:
    // the lowest entry in largest mode, the highest one in smallest mode.
    assign better = select_largest_reg ? (slot_valid[0] && !cell_ge[0])
                                       : |(slot_valid & ~cell_le);

    assign ctrl.insert        = op_insert && (!full || better);
    assign ctrl.replace_first = full && select_largest_reg;

    always_comb begin
        fill_next = fill_reg;
        if (op_clear) begin
            fill_next = '0;
        end else if (ctrl.insert && !full) begin
            fill_next = fill_reg + FW'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic                      left_le;
            logic signed [VALUE_W-1:0] right_value;
            logic                      right_le;

            assign slot_valid[g] = FW'(g) < fill_reg;

            if (g == 0) begin : g_head
                assign left_value = sample;
                assign left_le    = 1'b1;
            end else begin : g_link_l
                assign left_value = cell_value[g-1];
                assign left_le    = cell_le[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_value = sample;
                assign right_le    = 1'b0;
            end else begin : g_link_r
                assign right_value = cell_value[g+1];
                assign right_le    = cell_le[g+1];
            end

            mmns_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .sample      (sample),
                .slot_valid  (slot_valid[g]),
                .left_value  (left_value),
                .left_le     (left_le),
                .right_value (right_value),
                .right_le    (right_le),
                .value       (cell_value[g]),
                .le          (cell_le[g]),
                .ge          (cell_ge[g])
            );
        end
    endgenerate

    // Read-out walks the chain upward in smallest mode, downward otherwise.
    assign rd_pos   = select_largest_reg ? (fill_reg - FW'(1) - rd_cnt_reg) : rd_cnt_reg;
    assign rd_idx   = rd_pos[IW-1:0];
    assign last_now = ({1'b0, rd_cnt_reg} + (FW + 1)'(1)) >= {1'b0, fill_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (op_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (load_out && last_now) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_READ: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_cnt_next = rd_cnt_reg;
        if (op_read) begin
            rd_cnt_next = '0;
        end else if (load_out) begin
            rd_cnt_next = rd_cnt_reg + FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg     <= KEEP_W'(1);
            select_largest_reg <= 1'b0;
            fill_reg           <= '0;
            rd_cnt_reg         <= '0;
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEEP_COUNT:     keep_count_reg     <= cfg_wdata;
                    REG_SELECT_LARGEST: select_largest_reg <= cfg_wdata[0];
                    default:            keep_count_reg     <= keep_count_reg;
                endcase
            end
            fill_reg   <= fill_next;
            rd_cnt_reg <= rd_cnt_next;
            state_reg  <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // An empty store reads out as a single item without a value.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= (fill_reg == '0) ? '0 : cell_value[rd_idx];
            m_tuser_reg <= fill_reg != '0;
            m_tlast_reg <= last_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of min_max_n_selector. Commands stream in on the s_
// channel from a queue. A software copy of the sorted store predicts each
// read-out, and the m_ channel is checked field by field. Directed cases
// come first, then random phases under several keep counts and both modes,
// with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import mmns_pkg::*;

    localparam int          CAPACITY     = 16;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          IDLE_PCT     = 8;
    localparam int          LONG_HOLD    = 150;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          TIMEOUT_NS   = 400000;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic               is_null;
    } command_t;

    typedef struct {
        logic signed [31:0] kept_value;
        logic               has_value;
        logic               last_item;
    } readout_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;
    logic [2:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [KEEP_W-1:0]  cfg_wdata = '0;

    command_t           pending_cmds[$];
    readout_t           expected_reads[$];

    // Software copy of the selector state and its registers.
    logic signed [31:0] kept_vals[$];
    logic [KEEP_W-1:0]  keep_count_reg = 5'd1;
    logic               largest_mode   = 1'b0;

    int                 error_count  = 0;
    bit                 steady_mode  = 1'b0;
    int                 holds_asked  = 0;
    int                 holds_served = 0;
    int                 hold_left    = 0;

    min_max_n_selector #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // Applies one accepted command to the software store and queues the
    // values a read should produce.
    task automatic apply_command(input logic [1:0] op, input logic signed [31:0] v,
                                 input logic nul);
        int       eff;
        int       pos;
        int       idx;
        bit       take;
        readout_t item;
        case (op)
            OP_INSERT: begin
                if (!nul) begin
                    eff  = (keep_count_reg == 0) ? 1 :
                           (keep_count_reg > CAPACITY) ? CAPACITY : int'(keep_count_reg);
                    take = 1'b1;
                    // A full store only takes a value strictly better than its worst.
                    if (kept_vals.size() >= eff && kept_vals.size() > 0) begin
                        if (largest_mode) begin
                            take = (v > kept_vals[0]);
                            if (take) kept_vals.delete(0);
                        end else begin
                            take = (v < kept_vals[kept_vals.size() - 1]);
                            if (take) kept_vals.delete(kept_vals.size() - 1);
                        end
                    end
                    if (take) begin
                        pos = kept_vals.size();
                        while (pos > 0 && kept_vals[pos - 1] > v) pos--;
                        kept_vals.insert(pos, v);
                    end
                end
            end
            OP_READ: begin
                if (kept_vals.size() == 0) begin
                    item.kept_value = 0;
                    item.has_value  = 1'b0;
                    item.last_item  = 1'b1;
                    expected_reads.insert(expected_reads.size(), item);
                end else begin
                    for (int k = 0; k < kept_vals.size(); k++) begin
                        idx = largest_mode ? kept_vals.size() - 1 - k : k;
                        item.kept_value = kept_vals[idx];
                        item.has_value  = 1'b1;
                        item.last_item  = (k == kept_vals.size() - 1);
                        expected_reads.insert(expected_reads.size(), item);
                    end
                end
            end
            OP_CLEAR: begin
                kept_vals.delete();
            end
            default: begin
            end
        endcase
    endtask

    // Input driver: predicts on each accepted transaction, then offers the
    // next pending command unless it idles this cycle.
    always @(posedge aclk) begin : drive_input
        command_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser[1:0], s_tdata, s_tuser[2]);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 &&
                    (steady_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_cmds[0];
                    pending_cmds.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= {nxt.is_null, nxt.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : check_output
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch($sformatf("unexpected output transaction, value %0d",
                                          $signed(m_tdata)));
            end else begin
                want = expected_reads[0];
                expected_reads.delete(0);
                if (m_tdata !== want.kept_value)
                    report_mismatch($sformatf("kept_value %0d, expected %0d",
                                              $signed(m_tdata), want.kept_value));
                if (m_tuser !== want.has_value)
                    report_mismatch($sformatf("has_value %b, expected %b",
                                              m_tuser, want.has_value));
                if (m_tlast !== want.last_item)
                    report_mismatch($sformatf("last_item %b, expected %b",
                                              m_tlast, want.last_item));
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic signed [31:0] v,
                            input logic nul);
        command_t c;
        c.op      = op;
        c.value   = v;
        c.is_null = nul;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [KEEP_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_KEEP_COUNT) keep_count_reg = data;
        else largest_mode = data[0];
    endtask

    // Waits until every command is taken and every read-out has arrived, then
    // lets an insert or clear still in flight settle.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_reads.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic command_t random_command();
        command_t c;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 78)      c.op = OP_INSERT;
        else if (pick < 92) c.op = OP_READ;
        else if (pick < 97) c.op = OP_CLEAR;
        else                c.op = OP_UNUSED;
        c.is_null = ($urandom_range(99) < 10);
        // Small values make ties with the worst kept value frequent.
        case ($urandom_range(9))
            0:       c.value = VAL_MIN;
            1:       c.value = VAL_MAX;
            2, 3, 4: c.value = $signed($urandom_range(20)) - 10;
            default: c.value = $urandom();
        endcase
        return c;
    endfunction

    task automatic run_phase(input logic [KEEP_W-1:0] keep, input bit largest,
                             input int n_items, input bit no_idle, input bit long_hold);
        wait_idle();
        write_reg(REG_KEEP_COUNT, keep);
        write_reg(REG_SELECT_LARGEST, {{(KEEP_W-1){1'b0}}, largest});
        @(negedge aclk);
        steady_mode = no_idle;
        if (long_hold) begin
            // The read-out stalls behind the hold-off, so the input backs up.
            holds_asked++;
            for (int i = 0; i < 6; i++) push_cmd(OP_INSERT, $urandom(), 1'b0);
            push_cmd(OP_READ, $urandom(), 1'b0);
        end
        for (int i = 0; i < n_items; i++)
            pending_cmds.insert(pending_cmds.size(), random_command());
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest mode, three kept: empty read, extremes, null, replacement, tie.
        write_reg(REG_KEEP_COUNT, 5'd3);
        write_reg(REG_SELECT_LARGEST, 5'd0);
        @(negedge aclk);
        push_cmd(OP_READ,   0,       1'b0);
        push_cmd(OP_INSERT, VAL_MIN, 1'b0);
        push_cmd(OP_INSERT, VAL_MAX, 1'b0);
        push_cmd(OP_INSERT, 5,       1'b1);
        push_cmd(OP_INSERT, 0,       1'b0);
        push_cmd(OP_INSERT, -1,      1'b0);
        push_cmd(OP_INSERT, 0,       1'b0);
        push_cmd(OP_READ,   0,       1'b0);
        push_cmd(OP_UNUSED, VAL_MAX, 1'b1);

        // Mode flipped with values kept, then a keep count of zero on a
        // store that is already fuller than that.
        wait_idle();
        write_reg(REG_SELECT_LARGEST, 5'd1);
        @(negedge aclk);
        push_cmd(OP_READ,   0,  1'b0);
        push_cmd(OP_INSERT, 5,  1'b0);
        wait_idle();
        write_reg(REG_KEEP_COUNT, 5'd0);
        @(negedge aclk);
        push_cmd(OP_INSERT, -7, 1'b0);
        push_cmd(OP_INSERT, 2,  1'b0);
        push_cmd(OP_READ,   0,  1'b0);
        push_cmd(OP_CLEAR,  -1, 1'b1);
        push_cmd(OP_READ,   0,  1'b0);

        run_phase(5'd16, 1'b0, 40, 1'b0, 1'b0);
        run_phase(5'd31, 1'b1, 40, 1'b0, 1'b0);
        run_phase(5'd1,  1'b0, 35, 1'b0, 1'b0);
        run_phase(5'd0,  1'b1, 35, 1'b1, 1'b0);
        run_phase(5'd5,  1'b0, 40, 1'b1, 1'b1);
        run_phase(KEEP_W'($urandom_range(31)), 1'($urandom_range(1)), 40, 1'b0, 1'b0);
        run_phase(KEEP_W'($urandom_range(31)), 1'($urandom_range(1)), 40, 1'b0, 1'b0);
        run_phase(5'd17, 1'b1, 30, 1'b0, 1'b0);

        wait_idle();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[min_max_n_selector.f]
rtl/mmns_pkg.sv
rtl/mmns_cell.sv
rtl/min_max_n_selector.sv
test/testbench.sv
